### hw/rtl/rsr_pkg.sv
package rsr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_WRITE,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic load;
    logic reject;
    logic scan_start;
    logic scan_step;
    logic write_back;
    logic clear_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic clear_done;
    logic run_empty;
  } sts_t;

endpackage

### hw/rtl/replacement_selection_runs.sv
// replacement selection run generator
// command channel: start with kind_i/key_i is taken when busy is low.
//   kind 0 loads a key into the next free slot when there is room (no result);
//   kind 1 removes the least key of the current run and inserts key_i.
// results appear on the result ports for one cycle with valid_o high; the
//   receiver cannot stall, so results must be taken when shown.
// a rejected step (store not full) gives its result in the cycle after start.
// an accepted step scans every occupied slot through the key memory read
//   port, one slot a cycle; when the run ends, an extra clear step flips
//   the run tag parity.
// configuration: cfg_valid_i/cfg_ready_o writes store_size, only while idle.
// reset empties the store and sets store_size to 1024; run parity and
//   counters are cleared at once, the key memory is not cleared.
module replacement_selection_runs import rsr_pkg::*; #(
  parameter int DEPTH    = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                kind_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [10:0]         cfg_data_i,
  output logic                valid_o,
  output logic [31:0]         removed_key_o,
  output logic                run_end_o,
  output logic [31:0]         run_length_o,
  output logic [31:0]         run_index_o,
  output logic                status_o
);

  cmd_t        cmd;
  sts_t        sts;
  logic [10:0] size_q;

  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 11'd1024;
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

  rsr_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .kind_i(kind_i),
    .sts_i (sts),
    .cmd_o (cmd),
    .busy_o(busy)
  );

  rsr_dp #(.Depth(DEPTH), .KeyBits(KEY_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .key_i        (key_i),
    .size_i       (size_q),
    .valid_o      (valid_o),
    .removed_key_o(removed_key_o),
    .run_end_o    (run_end_o),
    .run_length_o (run_length_o),
    .run_index_o  (run_index_o),
    .status_o     (status_o)
  );

endmodule

### hw/rtl/rsr_ram.sv
module rsr_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/rsr_ctrl.sv
module rsr_ctrl import rsr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic kind_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;
  logic   go;

  assign go = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (go && kind_i && sts_i.full) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT:  state_d = ST_WRITE;
      ST_WRITE: state_d = sts_i.run_empty ? ST_CLEAR : ST_IDLE;
      ST_CLEAR: begin
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load       = go && !kind_i;
        cmd_o.reject     = go && kind_i && !sts_i.full;
        cmd_o.scan_start = go && kind_i && sts_i.full;
      end
      ST_SCAN:  cmd_o.scan_step = 1'b1;
      ST_WAIT:  cmd_o.scan_step = 1'b1;
      ST_WRITE: begin
        cmd_o.write_back = 1'b1;
        cmd_o.emit       = 1'b1;
      end
      ST_CLEAR: cmd_o.clear_step = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> (state_q == ST_IDLE || state_q == ST_CLEAR))
    else $error("write not followed by idle or clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.reject, cmd_o.scan_start}))
    else $error("conflicting commands");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |=> (state_q == ST_WRITE))
    else $error("wait not followed by write");

endmodule

### hw/rtl/rsr_dp.sv
module rsr_dp import rsr_pkg::*; #(
  parameter int Depth   = 1024,
  parameter int KeyBits = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [KeyBits-1:0] key_i,
  input  logic [10:0]        size_i,
  output logic               valid_o,
  output logic [31:0]        removed_key_o,
  output logic               run_end_o,
  output logic [31:0]        run_length_o,
  output logic [31:0]        run_index_o,
  output logic               status_o
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  logic [CW-1:0]      occ_q, cur_q;
  logic [31:0]        len_q, run_q;
  logic [KeyBits-1:0] new_q, least_q;
  logic [AW-1:0]      best_q;
  logic               found_q;
  logic [CW-1:0]      rd_q;
  logic [AW-1:0]      cmp_q;
  logic               cmp_v_q;
  logic               par_q;
  logic [KeyBits:0]   rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_wa;
  logic [KeyBits:0]   ram_wd;
  logic               is_less, run_end, new_tag;
  logic [CW-1:0]      cur_dec;

  assign sts_o.full       = (size_i != '0) && (32'(occ_q) >= 32'(size_i) || occ_q == CW'(Depth))
                            && (cur_q != '0);
  assign sts_o.scan_done  = (rd_q >= occ_q);
  assign sts_o.clear_done = 1'b1;
  assign is_less          = new_q < least_q;
  assign new_tag          = is_less ? ~par_q : par_q;
  assign cur_dec          = is_less ? cur_q - 1'b1 : cur_q;
  assign run_end          = (cur_dec == '0);
  assign sts_o.run_empty  = run_end;

  // each slot carries a run tag next to its key, current run when equal to par_q
  assign ram_we = cmd_i.load ? (32'(occ_q) < 32'(size_i) && occ_q < CW'(Depth))
                             : cmd_i.write_back;
  assign ram_wa = cmd_i.load ? occ_q[AW-1:0] : best_q;
  assign ram_wd = cmd_i.load ? {par_q, key_i} : {new_tag, new_q};

  rsr_ram #(.Width(KeyBits + 1), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i(ram_wd),
    .raddr_i(rd_q[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      new_q <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      cur_q   <= '0;
      len_q   <= '0;
      run_q   <= '0;
      par_q   <= 1'b0;
      rd_q    <= '0;
      cmp_q   <= '0;
      cmp_v_q <= 1'b0;
      found_q <= 1'b0;
      least_q <= '0;
      best_q  <= '0;
      valid_o <= 1'b0;
      removed_key_o <= '0;
      run_end_o     <= 1'b0;
      run_length_o  <= '0;
      run_index_o   <= '0;
      status_o      <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      if (cmd_i.load && ram_we) begin
        occ_q <= occ_q + 1'b1;
        cur_q <= cur_q + 1'b1;
      end
      if (cmd_i.reject) begin
        valid_o       <= 1'b1;
        removed_key_o <= '0;
        run_end_o     <= 1'b0;
        run_length_o  <= '0;
        run_index_o   <= '0;
        status_o      <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        rd_q    <= '0;
        cmp_v_q <= 1'b0;
        found_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (rd_q < occ_q) rd_q <= rd_q + 1'b1;
        cmp_v_q <= rd_q < occ_q;
        cmp_q   <= rd_q[AW-1:0];
        if (cmp_v_q && (rdata[KeyBits] == par_q) &&
            (!found_q || rdata[KeyBits-1:0] < least_q)) begin
          found_q <= 1'b1;
          least_q <= rdata[KeyBits-1:0];
          best_q  <= cmp_q;
        end
      end
      if (cmd_i.write_back) begin
        valid_o       <= 1'b1;
        removed_key_o <= 32'(least_q);
        run_end_o     <= run_end;
        run_length_o  <= (len_q == '1) ? len_q : len_q + 1'b1;
        run_index_o   <= run_q;
        status_o      <= 1'b0;
        if (run_end) begin
          cur_q <= occ_q;
          len_q <= '0;
          run_q <= run_q + 1'b1;
        end else begin
          cur_q <= cur_dec;
          len_q <= (len_q == '1) ? len_q : len_q + 1'b1;
        end
      end
      if (cmd_i.clear_step) begin
        par_q <= ~par_q;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_back |-> found_q)
    else $error("write back without a found key");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= occ_q)
    else $error("current count above occupancy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.write_back || cmd_i.reject) |=> valid_o)
    else $error("result not emitted");

endmodule
